// ===== design/goap_action_expand_defines.svh =====
// Assertion macros shared by the action expansion block.
`ifndef GOAP_ACTION_EXPAND_DEFINES_SVH
`define GOAP_ACTION_EXPAND_DEFINES_SVH

`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define GOAP_ASSERT_IMPLY(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("goap assertion failed");
// Antecedent implies consequent in the next cycle.
`define GOAP_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("goap assertion failed");
`else
`define GOAP_ASSERT_IMPLY(name, clk, rstn, ante, cons)
`define GOAP_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif

`endif

// ===== design/goap_pkg.sv =====
// Types, constants and helper functions of the action expansion block.
package goap_pkg;

    localparam int NUM_ATOMS   = 64;
    localparam int NUM_ACTIONS = 16;
    localparam int COST_BITS   = 16;

    localparam int IDX_W   = 4;
    localparam int ATOM_W  = 6;
    localparam int CNT_W   = 5;
    localparam int DIST_W  = 7;
    localparam int CFG_W   = 64;
    localparam int CFGI_W  = 2;
    localparam int NUM_BYTES = NUM_ATOMS / 8;

    typedef enum logic [1:0] {
        OP_SET_PRE  = 2'd0,
        OP_SET_POST = 2'd1,
        OP_SET_COST = 2'd2,
        OP_EXPAND   = 2'd3
    } op_t;

    typedef enum logic [CFGI_W-1:0] {
        REG_ACTION_COUNT = 2'd0,
        REG_GOAL_VALUES  = 2'd1,
        REG_GOAL_MASK    = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        op_t                  action;
        logic [IDX_W-1:0]     entry_index;
        logic [ATOM_W-1:0]    atom_index;
        logic                 atom_value;
        logic [15:0]          action_cost;
        logic [63:0]          state_values;
        logic [63:0]          state_mask;
    } goap_req_t;

    typedef struct packed {
        logic [IDX_W-1:0]     action_index;
        logic [15:0]          step_cost;
        logic [63:0]          next_values;
        logic [63:0]          next_mask;
        logic [DIST_W-1:0]    goal_distance;
        logic                 last;
    } goap_rsp_t;

    // Table write broadcast to every cell.
    typedef struct packed {
        logic                 we;
        op_t                  op;
        logic [IDX_W-1:0]     entry;
        logic [ATOM_W-1:0]    atom;
        logic                 value;
        logic [COST_BITS-1:0] cost;
    } goap_set_t;

    // State token walking down the chain.
    typedef struct packed {
        logic                 valid;
        logic [NUM_ATOMS-1:0] values;
        logic [NUM_ATOMS-1:0] mask;
    } goap_tok_t;

    // Match result of one cell, all zero when there is no match.
    typedef struct packed {
        logic                 hit;
        logic [IDX_W-1:0]     index;
        logic [COST_BITS-1:0] cost;
        logic [NUM_ATOMS-1:0] next_values;
        logic [NUM_ATOMS-1:0] next_mask;
    } goap_hit_t;

    // Status from the result collector back to the chain control.
    typedef struct packed {
        logic stall;
        logic flush_done;
    } goap_stat_t;

    function automatic logic [3:0] byte_popcount(input logic [7:0] b);
        logic [3:0] n;
        n = '0;
        for (int k = 0; k < 8; k++) begin
            n = n + 4'(b[k]);
        end
        return n;
    endfunction

endpackage

// ===== design/goap_cell.sv =====
// One action table entry with its stage of the state token chain.
module goap_cell
    import goap_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [IDX_W-1:0] cell_index,
    input  logic             in_use,
    input  logic             advance,
    input  goap_set_t        set,
    input  goap_tok_t        tok_in,
    output goap_tok_t        tok_out,
    output goap_hit_t        hit
);

    logic [NUM_ATOMS-1:0] pre_mask_reg,  pre_mask_next;
    logic [NUM_ATOMS-1:0] pre_value_reg, pre_value_next;
    logic [NUM_ATOMS-1:0] post_mask_reg, post_mask_next;
    logic [NUM_ATOMS-1:0] post_value_reg, post_value_next;
    logic [COST_BITS-1:0] cost_reg, cost_next;
    logic                 tok_valid_reg;
    logic [NUM_ATOMS-1:0] tok_values_reg;
    logic [NUM_ATOMS-1:0] tok_mask_reg;

    logic                 sel;
    logic                 atom_ok;
    logic [NUM_ATOMS-1:0] atom_bit;
    logic                 match;

    always_comb begin
        sel      = set.we && (set.entry == cell_index);
        atom_ok  = {1'b0, set.atom} < (ATOM_W+1)'(NUM_ATOMS);
        atom_bit = NUM_ATOMS'(1) << set.atom;

        pre_mask_next   = pre_mask_reg;
        pre_value_next  = pre_value_reg;
        post_mask_next  = post_mask_reg;
        post_value_next = post_value_reg;
        cost_next       = cost_reg;

        if (sel) begin
            case (set.op)
                OP_SET_PRE: begin
                    if (atom_ok) begin
                        pre_mask_next  = pre_mask_reg | atom_bit;
                        pre_value_next = set.value ? (pre_value_reg | atom_bit)
                                                   : (pre_value_reg & ~atom_bit);
                    end
                end
                OP_SET_POST: begin
                    if (atom_ok) begin
                        post_mask_next  = post_mask_reg | atom_bit;
                        post_value_next = set.value ? (post_value_reg | atom_bit)
                                                    : (post_value_reg & ~atom_bit);
                    end
                end
                OP_SET_COST: begin
                    cost_next = set.cost;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_mask_reg   <= '0;
            pre_value_reg  <= '0;
            post_mask_reg  <= '0;
            post_value_reg <= '0;
            cost_reg       <= COST_BITS'(1);
            tok_valid_reg  <= 1'b0;
        end else begin
            pre_mask_reg   <= pre_mask_next;
            pre_value_reg  <= pre_value_next;
            post_mask_reg  <= post_mask_next;
            post_value_reg <= post_value_next;
            cost_reg       <= cost_next;
            if (advance) begin
                tok_valid_reg <= tok_in.valid;
            end
        end
    end

    // Token payload follows the valid bit; no reset needed.
    always_ff @(posedge aclk) begin
        if (advance) begin
            tok_values_reg <= tok_in.values;
            tok_mask_reg   <= tok_in.mask;
        end
    end

    always_comb begin
        tok_out.valid  = tok_valid_reg;
        tok_out.values = tok_values_reg;
        tok_out.mask   = tok_mask_reg;

        match = tok_valid_reg && in_use &&
                (((pre_value_reg ^ tok_values_reg) & pre_mask_reg) == '0);

        hit = '0;
        if (match) begin
            hit.hit         = 1'b1;
            hit.index       = cell_index;
            hit.cost        = cost_reg;
            hit.next_values = (tok_values_reg & ~post_mask_reg)
                            | (post_value_reg & post_mask_reg);
            hit.next_mask   = tok_mask_reg | post_mask_reg;
        end
    end

endmodule

// ===== design/goap_collect.sv =====
// Result collector: holds one match back to mark the last, then registers it out.
module goap_collect
    import goap_pkg::*;
`include "goap_action_expand_defines.svh"
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  goap_hit_t            hit,
    input  logic                 flush,
    input  logic [NUM_ATOMS-1:0] goal_values,
    input  logic [NUM_ATOMS-1:0] goal_mask,
    output logic                 m_valid,
    input  logic                 m_ready,
    output goap_rsp_t            m_request,
    output goap_stat_t           stat
);

    logic                 pend_valid_reg, pend_valid_next;
    goap_hit_t            pend_hit_reg;
    logic [3:0]           pend_cnt_reg [NUM_BYTES];
    logic                 m_valid_reg, m_valid_next;
    goap_rsp_t            out_reg;

    logic                 out_free;
    logic                 take_hit;
    logic                 push_mid;
    logic                 push_last;
    logic [NUM_ATOMS-1:0] diff;
    logic [3:0]           cnt_next [NUM_BYTES];
    logic [DIST_W-1:0]    goal_dist;

    always_comb begin
        out_free  = !m_valid_reg || m_ready;
        stat.stall = hit.hit && pend_valid_reg && !out_free;
        take_hit  = hit.hit && !stat.stall;
        push_mid  = take_hit && pend_valid_reg;
        push_last = flush && pend_valid_reg && out_free;
        stat.flush_done = flush && (!pend_valid_reg || out_free);

        pend_valid_next = pend_valid_reg;
        if (take_hit) begin
            pend_valid_next = 1'b1;
        end else if (push_last) begin
            pend_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (push_mid || push_last) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        // Goal mismatches counted per byte now, summed at the output push.
        diff = goal_mask & (hit.next_values ^ goal_values);
        for (int b = 0; b < NUM_BYTES; b++) begin
            cnt_next[b] = byte_popcount(diff[b*8 +: 8]);
        end

        goal_dist = '0;
        for (int b = 0; b < NUM_BYTES; b++) begin
            goal_dist = goal_dist + DIST_W'(pend_cnt_reg[b]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take_hit) begin
            pend_hit_reg <= hit;
            pend_cnt_reg <= cnt_next;
        end
        if (push_mid || push_last) begin
            out_reg.action_index  <= pend_hit_reg.index;
            out_reg.step_cost     <= pend_hit_reg.cost;
            out_reg.next_values   <= pend_hit_reg.next_values;
            out_reg.next_mask     <= pend_hit_reg.next_mask;
            out_reg.goal_distance <= goal_dist;
            out_reg.last          <= push_last;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_request = out_reg;

    `GOAP_ASSERT_NEXT(a_last_pushed, aclk, aresetn, push_last, m_valid_reg && out_reg.last && !pend_valid_reg)
    `GOAP_ASSERT_NEXT(a_stall_holds, aclk, aresetn, stat.stall, pend_valid_reg)
    `GOAP_ASSERT_IMPLY(a_no_hit_in_flush, aclk, aresetn, flush, !hit.hit)

endmodule

// ===== design/goap_action_expand.sv =====
// Top level of the goal-oriented action planner expansion engine.
//
//  channel  direction  handshake               payload
//  s_       in         s_valid / s_ready       s_request (goap_req_t)
//  m_       out        m_valid / m_ready       m_request (goap_rsp_t)
//  cfg_     in         cfg_we (no wait)        cfg_index, cfg_wdata
//
// A set request (precondition atom, postcondition atom, cost) writes the addressed entry.
// An expand request walks a token down a chain of NUM_ACTIONS cells, one cell
// per cycle unless stalled, and then drains the held match; no new request is
// accepted until the drain is done. The walk stalls while a full output
// register waits on m_ready and a further match waits.
// Reset (aresetn low, synchronous) clears the table to zero with all costs one
// and clears the valid flags and configuration registers; no sweep follows.
// A result in the output register blocks a new request only while a further match waits.
module goap_action_expand
    import goap_pkg::*;
`include "goap_action_expand_defines.svh"
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  goap_req_t         s_request,
    output logic              m_valid,
    input  logic              m_ready,
    output goap_rsp_t         m_request,
    input  logic              cfg_we,
    input  logic [CFGI_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_wdata
);

    // Configuration registers.
    logic [CNT_W-1:0]     count_reg;
    logic [NUM_ATOMS-1:0] goal_values_reg;
    logic [NUM_ATOMS-1:0] goal_mask_reg;

    // Drain flag: the token has left the chain, the held match still goes out.
    logic                 flush_reg, flush_next;

    logic                 accept;
    logic                 expand_acc;
    logic                 advance;
    logic                 tok_any;
    logic [CNT_W-1:0]     used;
    logic [NUM_ACTIONS-1:0] in_use;
    logic [NUM_ACTIONS-1:0] tok_vec;
    goap_set_t            set;
    goap_tok_t            tok_chain [NUM_ACTIONS+1];
    goap_hit_t            cell_hit  [NUM_ACTIONS];
    goap_hit_t            hit_sel;
    goap_stat_t           stat;

    // Configuration writes: the user must write only while idle, so no hazard with a running walk; not enforced here.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg       <= '0;
            goal_values_reg <= '0;
            goal_mask_reg   <= '0;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_ACTION_COUNT: count_reg       <= cfg_wdata[CNT_W-1:0];
                REG_GOAL_VALUES:  goal_values_reg <= cfg_wdata[NUM_ATOMS-1:0];
                REG_GOAL_MASK:    goal_mask_reg   <= cfg_wdata[NUM_ATOMS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        // Clamp the entry count to the table size.
        used = (count_reg > CNT_W'(NUM_ACTIONS)) ? CNT_W'(NUM_ACTIONS) : count_reg;
        for (int i = 0; i < NUM_ACTIONS; i++) begin
            in_use[i]  = CNT_W'(i) < used;
            tok_vec[i] = tok_chain[i+1].valid;
        end
        tok_any = |tok_vec;

        // One request in flight at a time: chain busy or draining blocks input.
        s_ready    = !tok_any && !flush_reg;
        accept     = s_valid && s_ready;
        expand_acc = accept && (s_request.action == OP_EXPAND);

        // Hold the whole chain while the collector cannot take a match.
        advance = !stat.stall;

        set.we    = accept && (s_request.action != OP_EXPAND);
        set.op    = s_request.action;
        set.entry = s_request.entry_index;
        set.atom  = s_request.atom_index;
        set.value = s_request.atom_value;
        set.cost  = s_request.action_cost[COST_BITS-1:0];

        // At most one cell holds the token, so an OR picks its match.
        hit_sel = '0;
        for (int i = 0; i < NUM_ACTIONS; i++) begin
            hit_sel = hit_sel | cell_hit[i];
        end

        // Advance into drain when the token leaves the tail cell.
        flush_next = flush_reg;
        if (tok_vec[NUM_ACTIONS-1] && advance) begin
            flush_next = 1'b1;
        end else if (stat.flush_done) begin
            flush_next = 1'b0;
        end
    end

    // Unset atoms read as false.
    assign tok_chain[0].valid  = expand_acc;
    assign tok_chain[0].values = s_request.state_values & s_request.state_mask;
    assign tok_chain[0].mask   = s_request.state_mask;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flush_reg <= 1'b0;
        end else begin
            flush_reg <= flush_next;
        end
    end

    for (genvar g = 0; g < NUM_ACTIONS; g++) begin : g_cell
        goap_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cell_index (IDX_W'(g)),
            .in_use     (in_use[g]),
            .advance    (advance),
            .set        (set),
            .tok_in     (tok_chain[g]),
            .tok_out    (tok_chain[g+1]),
            .hit        (cell_hit[g])
        );
    end

    goap_collect u_collect (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .hit         (hit_sel),
        .flush       (flush_reg),
        .goal_values (goal_values_reg),
        .goal_mask   (goal_mask_reg),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_request   (m_request),
        .stat        (stat)
    );

    `GOAP_ASSERT_IMPLY(a_single_token, aclk, aresetn, 1'b1, $onehot0(tok_vec))
    `GOAP_ASSERT_IMPLY(a_drain_chain_empty, aclk, aresetn, flush_reg, !tok_any)
    `GOAP_ASSERT_NEXT(a_token_enters, aclk, aresetn, expand_acc, tok_vec[0])

endmodule
